// ===== src/ufr_pkg.sv =====
// Shared types, constants and status codes for the UDP frame fragment reassembler.
// Used by every module of the block but ufr_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  localparam int MAX_PACKETS  = 1024;
  localparam int HEADER_BYTES = 16;

  localparam int ROW_BITS = 32;
  localparam int BIT_AW   = $clog2(ROW_BITS);
  localparam int MAP_ROWS = (MAX_PACKETS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  localparam logic [16:0] HEADER_LEN = 17'(HEADER_BYTES);
  localparam logic [15:0] MAX_PKT    = 16'(MAX_PACKETS);
  localparam logic [31:0] FRAME_CAP  = 32'd16777216;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SENDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd2;

  localparam logic [15:0] PAYLOAD_LIMIT_RST   = 16'd1400;
  localparam logic [24:0] MAX_FRAME_BYTES_RST = 25'd1048576;

  typedef enum logic [3:0] {
    ST_ACCEPTED        = 4'd0,
    ST_WRONG_SENDER    = 4'd1,
    ST_SHORT           = 4'd2,
    ST_BAD_FRAME_SIZE  = 4'd3,
    ST_ZERO_COUNT      = 4'd4,
    ST_INDEX_RANGE     = 4'd5,
    ST_BAD_PAYLOAD     = 4'd6,
    ST_LENGTH_MISMATCH = 4'd7,
    ST_COUNT_MISMATCH  = 4'd8,
    ST_OVERRUN         = 4'd9,
    ST_DUPLICATE       = 4'd10,
    ST_TOO_MANY        = 4'd11
  } status_t;

  typedef struct packed {
    logic [31:0] sender_address;
    logic [15:0] datagram_length;
    logic [31:0] frame_id;
    logic [31:0] frame_size;
    logic [15:0] packet_count;
    logic [15:0] packet_index;
    logic [15:0] payload_size;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] write_offset;
    logic [15:0] write_length;
    logic        frame_complete;
    logic [24:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [31:0] expected_sender;
    logic [15:0] payload_limit;
    logic [24:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic                clear;
    logic [ROW_AW-1:0]   row;
    logic [ROW_BITS-1:0] data;
  } map_upd_t;

endpackage

`default_nettype wire

// ===== src/ufr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ufr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ufr_bitmap.sv =====
// Received-packet bitmap: rows of packet bits in a RAM, a valid bit per row for
// instant clearing, and a bypass for a row written at the read edge. Uses ufr_pkg, ufr_ram.
`timescale 1ns / 1ps
`default_nettype none

module ufr_bitmap
  import ufr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [ROW_AW-1:0]   rd_row,
  input  wire map_upd_t            upd,
  output logic      [ROW_BITS-1:0] row_bits
);

  logic [ROW_BITS-1:0] ram_q;
  logic [MAP_ROWS-1:0] row_valid_r;
  logic [MAP_ROWS-1:0] row_valid_nxt;
  logic [ROW_AW-1:0]   row_r;
  logic                fwd_hit_r;
  logic [ROW_BITS-1:0] fwd_data_r;

  ufr_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAP_ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (upd.en),
    .wr_addr (upd.row),
    .wr_data (upd.data),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (ram_q)
  );

  always_comb begin
    row_valid_nxt = row_valid_r;
    if (upd.clear) begin
      row_valid_nxt = '0;
    end
    if (upd.en) begin
      row_valid_nxt[upd.row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r      <= rd_row;
      fwd_hit_r  <= upd.en && (upd.row == rd_row);
      fwd_data_r <= upd.data;
    end
  end

  assign row_bits = row_valid_r[row_r] ? (fwd_hit_r ? fwd_data_r : ram_q) : '0;

endmodule

`default_nettype wire

// ===== src/ufr_tracker.sv =====
// Header checks, frame tracking state and result formation for one registered word.
// Uses ufr_pkg; reads the bitmap row prepared by ufr_bitmap.
`timescale 1ns / 1ps
`default_nettype none

module ufr_tracker
  import ufr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire item_t               item,
  input  wire cfg_t                cfg,
  input  wire logic                fire,
  input  wire logic [ROW_BITS-1:0] row_bits,
  output result_t                  result,
  output map_upd_t                 upd
);

  logic        frame_active_r, frame_active_nxt;
  logic [31:0] current_frame_r, current_frame_nxt;
  logic [15:0] expected_r, expected_nxt;
  logic [15:0] received_r, received_nxt;
  logic [24:0] frame_bytes_r, frame_bytes_nxt;

  logic [16:0]         len_sum;
  logic                size_bad;
  logic                pre_ok;
  status_t             pre_status;
  status_t             status;
  logic                restart;
  logic [15:0]         exp_eff;
  logic [15:0]         recv_eff;
  logic [15:0]         recv_inc;
  logic [24:0]         bytes_eff;
  logic [ROW_BITS-1:0] bits_eff;
  logic [31:0]         offset;
  logic [32:0]         end_pos;
  logic                overrun;
  logic                dup;
  logic                accept;
  logic                complete;

  always_comb begin
    len_sum  = {1'b0, item.payload_size} + HEADER_LEN;
    size_bad = (item.frame_size == 32'd0) ||
               (item.frame_size > {7'd0, cfg.max_frame_bytes}) ||
               (item.frame_size > FRAME_CAP);
    pre_ok     = 1'b0;
    pre_status = ST_ACCEPTED;
    priority if (item.sender_address != cfg.expected_sender) begin
      pre_status = ST_WRONG_SENDER;
    end else if ({1'b0, item.datagram_length} < HEADER_LEN) begin
      pre_status = ST_SHORT;
    end else if (size_bad) begin
      pre_status = ST_BAD_FRAME_SIZE;
    end else if (item.packet_count == 16'd0) begin
      pre_status = ST_ZERO_COUNT;
    end else if (item.packet_index >= item.packet_count) begin
      pre_status = ST_INDEX_RANGE;
    end else if ((item.payload_size == 16'd0) ||
                 (item.payload_size > cfg.payload_limit)) begin
      pre_status = ST_BAD_PAYLOAD;
    end else if ({1'b0, item.datagram_length} != len_sum) begin
      pre_status = ST_LENGTH_MISMATCH;
    end else if (item.packet_count > MAX_PKT) begin
      pre_status = ST_TOO_MANY;
    end else begin
      pre_ok = 1'b1;
    end

    restart   = pre_ok && (!frame_active_r || (item.frame_id != current_frame_r));
    exp_eff   = restart ? item.packet_count : expected_r;
    recv_eff  = restart ? 16'd0 : received_r;
    bytes_eff = restart ? item.frame_size[24:0] : frame_bytes_r;
    bits_eff  = restart ? '0 : row_bits;

    offset   = 32'(item.packet_index) * 32'(cfg.payload_limit);
    end_pos  = {1'b0, offset} + 33'(item.payload_size);
    overrun  = end_pos > 33'(bytes_eff);
    dup      = bits_eff[item.packet_index[BIT_AW-1:0]];
    recv_inc = recv_eff + 16'd1;
    complete = (recv_inc == exp_eff);

    accept = 1'b0;
    priority if (!pre_ok) begin
      status = pre_status;
    end else if (item.packet_count != exp_eff) begin
      status = ST_COUNT_MISMATCH;
    end else if (overrun) begin
      status = ST_OVERRUN;
    end else if (dup) begin
      status = ST_DUPLICATE;
    end else begin
      status = ST_ACCEPTED;
      accept = 1'b1;
    end

    frame_active_nxt  = frame_active_r;
    current_frame_nxt = current_frame_r;
    expected_nxt      = expected_r;
    received_nxt      = received_r;
    frame_bytes_nxt   = frame_bytes_r;
    if (restart) begin
      frame_active_nxt  = 1'b1;
      current_frame_nxt = item.frame_id;
      expected_nxt      = item.packet_count;
      received_nxt      = 16'd0;
      frame_bytes_nxt   = item.frame_size[24:0];
    end
    if (accept) begin
      received_nxt = recv_inc;
      if (complete) begin
        frame_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r  <= 1'b0;
      current_frame_r <= '0;
      expected_r      <= '0;
      received_r      <= '0;
      frame_bytes_r   <= '0;
    end else if (fire) begin
      frame_active_r  <= frame_active_nxt;
      current_frame_r <= current_frame_nxt;
      expected_r      <= expected_nxt;
      received_r      <= received_nxt;
      frame_bytes_r   <= frame_bytes_nxt;
    end
  end

  always_comb begin
    upd.en    = fire && accept;
    upd.clear = fire && restart;
    upd.row   = item.packet_index[BIT_AW +: ROW_AW];
    upd.data  = bits_eff | (ROW_BITS'(1) << item.packet_index[BIT_AW-1:0]);

    result.status         = status;
    result.write_offset   = accept ? offset[23:0] : 24'd0;
    result.write_length   = accept ? item.payload_size : 16'd0;
    result.frame_complete = accept && complete;
    result.frame_length   = frame_bytes_nxt;
  end

endmodule

`default_nettype wire

// ===== src/udp_frame_fragment_reassembler.sv =====
// Top level of the UDP frame fragment reassembler: input register, result register,
// configuration registers. Uses ufr_pkg, ufr_tracker and ufr_bitmap.
//
// Each input word is the descriptor of one received datagram: sender, length and
// the header fields of the frame fragment. Each result word gives a status code
// and, for an accepted packet, the byte offset and length that an external mover
// uses to copy the payload into the frame store, plus a frame-complete flag.
// Both channels use valid and stall; a word moves when valid is high and stall
// is low. Configuration registers are written through the cfg port, which is
// always ready, and should only be written while no word is in flight.
// A word accepted into the input register is checked from there, and its result is loaded
// into the output register when the output register is free to take it.
// Throughput is one word per cycle while the receiver does not stall; the received-packet
// bitmap is one RAM row read at acceptance and written back when its result is loaded, with a bypass.
// When the receiver stalls, the result register holds and the input register
// keeps accepting until it is also full, then in_stall rises.
// Reset clears both valid flags, frame tracking and the bitmap row valid bits,
// and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module udp_frame_fragment_reassembler
  import ufr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [31:0]           in_sender_address,
  input  wire logic [15:0]           in_datagram_length,
  input  wire logic [31:0]           in_frame_id,
  input  wire logic [31:0]           in_frame_size,
  input  wire logic [15:0]           in_packet_count,
  input  wire logic [15:0]           in_packet_index,
  input  wire logic [15:0]           in_payload_size,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_status,
  output logic [23:0]                out_write_offset,
  output logic [15:0]                out_write_length,
  output logic                       out_frame_complete,
  output logic [24:0]                out_frame_length,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  cfg_t    cfg_r, cfg_nxt;

  logic                out_free;
  logic                s1_fire;
  logic                in_accept;
  item_t               in_item;
  result_t             res;
  map_upd_t            upd;
  logic [ROW_BITS-1:0] row_bits;

  assign in_item = '{
    sender_address:  in_sender_address,
    datagram_length: in_datagram_length,
    frame_id:        in_frame_id,
    frame_size:      in_frame_size,
    packet_count:    in_packet_count,
    packet_index:    in_packet_index,
    payload_size:    in_payload_size
  };

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXPECTED_SENDER: cfg_nxt.expected_sender = cfg_data[31:0];
        CFG_PAYLOAD_LIMIT:   cfg_nxt.payload_limit   = cfg_data[15:0];
        CFG_MAX_FRAME_BYTES: cfg_nxt.max_frame_bytes = cfg_data[24:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{expected_sender: 32'd0,
                       payload_limit:   PAYLOAD_LIMIT_RST,
                       max_frame_bytes: MAX_FRAME_BYTES_RST};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  ufr_bitmap u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_row   (in_packet_index[BIT_AW +: ROW_AW]),
    .upd      (upd),
    .row_bits (row_bits)
  );

  ufr_tracker u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (s1_item_r),
    .cfg      (cfg_r),
    .fire     (s1_fire),
    .row_bits (row_bits),
    .result   (res),
    .upd      (upd)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_write_offset   = out_res_r.write_offset;
  assign out_write_length   = out_res_r.write_length;
  assign out_frame_complete = out_res_r.frame_complete;
  assign out_frame_length   = out_res_r.frame_length;

endmodule

`default_nettype wire

// ===== src/ufr_checker.sv =====
// Port-level checker for the UDP frame fragment reassembler, bound to the top level.
// Uses ufr_pkg for status codes and widths.
`timescale 1ns / 1ps
`default_nettype none

module ufr_checker
  import ufr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  out_status,
  input wire logic [23:0] out_write_offset,
  input wire logic [15:0] out_write_length,
  input wire logic        out_frame_complete,
  input wire logic [24:0] out_frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_write_offset) && $stable(out_frame_length))
    else $error("stalled result word changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ACCEPTED) |->
      (out_write_offset == 24'd0) && (out_write_length == 16'd0) && !out_frame_complete)
    else $error("rejected word carries a copy request");

  a_accept_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED) |->
      (out_write_length != 16'd0) && (out_frame_length != 25'd0))
    else $error("accepted word with empty payload or frame");

  a_accept_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED) |->
      ({1'b0, out_write_offset} + 25'(out_write_length)) <= out_frame_length)
    else $error("accepted word overruns the frame");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind udp_frame_fragment_reassembler ufr_checker u_ufr_checker (.*);

`default_nettype wire
